### src/duart_pkg.sv
`timescale 1ns / 1ps

package duart_pkg;

    // operation codes on the input channel
    localparam logic [1:0] OP_TICK = 2'd0;
    localparam logic [1:0] OP_RAW  = 2'd1;
    localparam logic [1:0] OP_DEC3 = 2'd2;
    localparam logic [1:0] OP_DEC5 = 2'd3;

    localparam int          GAP_BITS         = 20;
    localparam logic [4:0]  GAP_LAST         = 5'(GAP_BITS);
    localparam logic [15:0] BIT_PERIOD_RESET = 16'd104;
    localparam logic [7:0]  ASCII_ZERO       = 8'h30;

    // floor(r / 10) = (r * RECIP10) >> RECIP_SHIFT for r below 10000
    localparam logic [15:0] RECIP10     = 16'd52429;
    localparam int          RECIP_SHIFT = 19;

    // classified request as it travels from front to back
    typedef struct packed {
        logic        is_tick;
        logic [2:0]  nchars;   // characters in the request
        logic [7:0]  lead;     // first character to send
        logic [13:0] rest;     // value left for the trailing digits
    } item_t;

endpackage

### src/duart_front.sv
`timescale 1ns / 1ps

module duart_front (
    input  logic [1:0]      operation,
    input  logic [15:0]     value,
    output duart_pkg::item_t item
);
    import duart_pkg::*;

    logic [7:0]  byte_val;
    logic [1:0]  hund;
    logic [6:0]  byte_rest;
    logic [2:0]  tenk;
    logic [13:0] word_rest;

    assign byte_val = value[7:0];

    // leading hundreds digit by compare
    always_comb begin
        if (byte_val >= 8'd200) begin
            hund      = 2'd2;
            byte_rest = 7'(byte_val - 8'd200);
        end else if (byte_val >= 8'd100) begin
            hund      = 2'd1;
            byte_rest = 7'(byte_val - 8'd100);
        end else begin
            hund      = 2'd0;
            byte_rest = byte_val[6:0];
        end
    end

    // leading ten-thousands digit, 0..6
    always_comb begin
        tenk = 3'(int'(value >= 16'd10000) + int'(value >= 16'd20000)
                + int'(value >= 16'd30000) + int'(value >= 16'd40000)
                + int'(value >= 16'd50000) + int'(value >= 16'd60000));
        case (tenk)
            3'd1:    word_rest = 14'(value - 16'd10000);
            3'd2:    word_rest = 14'(value - 16'd20000);
            3'd3:    word_rest = 14'(value - 16'd30000);
            3'd4:    word_rest = 14'(value - 16'd40000);
            3'd5:    word_rest = 14'(value - 16'd50000);
            3'd6:    word_rest = 14'(value - 16'd60000);
            default: word_rest = value[13:0];
        endcase
    end

    always_comb begin
        item = '0;
        case (operation)
            OP_TICK: begin
                item.is_tick = 1'b1;
            end
            OP_RAW: begin
                item.nchars = 3'd1;
                item.lead   = byte_val;
            end
            OP_DEC3: begin
                item.nchars = 3'd3;
                item.lead   = ASCII_ZERO + {6'd0, hund};
                item.rest   = {7'd0, byte_rest};
            end
            default: begin
                item.nchars = 3'd5;
                item.lead   = ASCII_ZERO + {5'd0, tenk};
                item.rest   = word_rest;
            end
        endcase
    end

endmodule

### src/duart_queue.sv
`timescale 1ns / 1ps

module duart_queue (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  duart_pkg::item_t push_item,
    output logic             full,
    input  logic             pop,
    output logic             not_empty,
    output duart_pkg::item_t head
);
    import duart_pkg::*;

    item_t       slot_reg [2];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  count_reg, count_next;

    assign full      = (count_reg == 2'd2);
    assign not_empty = (count_reg != 2'd0);
    assign head      = slot_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

### src/duart_back.sv
`timescale 1ns / 1ps

module duart_back (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_wr_en,
    input  logic [15:0]      cfg_wr_data,
    input  logic             q_valid,
    input  duart_pkg::item_t q_item,
    output logic             q_pop,
    output logic             m_valid,
    input  logic             m_ready,
    output logic             m_line_level,
    output logic             m_line_driven,
    output logic             m_busy_res,
    output logic             m_rejected
);
    import duart_pkg::*;

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_SEND = 2'd1;
    localparam logic [1:0] PH_GAP  = 2'd2;

    logic [15:0] bit_period_reg;
    logic [1:0]  phase_reg, phase_next;
    logic [4:0]  bit_index_reg, bit_index_next;
    logic [15:0] tick_count_reg, tick_count_next;
    logic [7:0]  shift_reg, shift_next;
    logic [2:0]  chars_left_reg, chars_left_next;
    logic [7:0]  char_queue [5];

    logic [13:0] dig_rem_reg, dig_rem_next;
    logic [2:0]  dig_cnt_reg, dig_cnt_next;
    logic [2:0]  dig_idx_reg, dig_idx_next;
    logic [29:0] dig_prod;
    logic [13:0] dig_quot;
    logic [13:0] dig_q10;
    logic [3:0]  dig_val;
    logic        dig_wr;

    logic        m_valid_reg;
    logic        level_reg, driven_reg, busy_reg, rej_reg;

    logic        load;
    logic        rej_now;
    logic        period_end;
    logic [16:0] tick_inc;
    logic [4:0]  bit_inc;
    logic [2:0]  slot;
    logic [2:0]  tap;
    logic        level_now;

    assign q_pop = q_valid && (!m_valid_reg || m_ready);

    // bit timing
    assign tick_inc   = {1'b0, tick_count_reg} + 17'd1;
    assign period_end = (tick_inc >= {1'b0, bit_period_reg});
    assign bit_inc    = bit_index_reg + 5'd1;
    assign slot       = chars_left_reg - 3'd1;

    always_comb begin
        phase_next      = phase_reg;
        bit_index_next  = bit_index_reg;
        tick_count_next = tick_count_reg;
        shift_next      = shift_reg;
        chars_left_next = chars_left_reg;
        load            = 1'b0;
        rej_now         = 1'b0;
        if (q_pop) begin
            if (q_item.is_tick) begin
                case (phase_reg)
                    PH_SEND: begin
                        tick_count_next = period_end ? 16'd0 : tick_inc[15:0];
                        if (period_end) begin
                            if (bit_inc >= 5'd9) begin
                                bit_index_next = 5'd0;
                                phase_next     = PH_GAP;
                            end else begin
                                bit_index_next = bit_inc;
                            end
                        end
                    end
                    PH_GAP: begin
                        tick_count_next = period_end ? 16'd0 : tick_inc[15:0];
                        if (period_end) begin
                            bit_index_next = bit_inc;
                            if (bit_inc >= GAP_LAST || bit_inc == 5'd0) begin
                                bit_index_next = 5'd0;
                                if (chars_left_reg != 3'd0) begin
                                    shift_next      = char_queue[slot];
                                    chars_left_next = slot;
                                    phase_next      = PH_SEND;
                                end else begin
                                    phase_next = PH_IDLE;
                                end
                            end
                        end
                    end
                    default: begin
                        phase_next = PH_IDLE;
                    end
                endcase
            end else if (phase_reg == PH_SEND || phase_reg == PH_GAP) begin
                rej_now = 1'b1;
            end else begin
                load            = 1'b1;
                shift_next      = q_item.lead;
                chars_left_next = q_item.nchars - 3'd1;
                bit_index_next  = 5'd0;
                tick_count_next = 16'd0;
                phase_next      = PH_SEND;
            end
        end
    end

    // trailing digits, least significant first, one per cycle
    assign dig_prod = {16'd0, dig_rem_reg} * {14'd0, RECIP10};
    assign dig_quot = 14'(dig_prod >> RECIP_SHIFT);
    assign dig_q10  = {dig_quot[10:0], 3'b000} + {dig_quot[12:0], 1'b0};
    assign dig_val  = 4'(dig_rem_reg - dig_q10);
    assign dig_wr   = (dig_cnt_reg != 3'd0);

    always_comb begin
        dig_rem_next = dig_rem_reg;
        dig_cnt_next = dig_cnt_reg;
        dig_idx_next = dig_idx_reg;
        if (load) begin
            dig_rem_next = q_item.rest;
            dig_cnt_next = q_item.nchars - 3'd1;
            dig_idx_next = 3'd0;
        end else if (dig_wr) begin
            dig_rem_next = dig_quot;
            dig_cnt_next = dig_cnt_reg - 3'd1;
            dig_idx_next = dig_idx_reg + 3'd1;
        end
    end

    // line as seen after this item
    assign tap = 3'(bit_index_next - 5'd1);
    always_comb begin
        if (phase_next == PH_SEND) begin
            level_now = (bit_index_next == 5'd0) ? 1'b0 : shift_next[tap];
        end else begin
            level_now = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bit_period_reg <= BIT_PERIOD_RESET;
            phase_reg      <= PH_IDLE;
            bit_index_reg  <= 5'd0;
            tick_count_reg <= 16'd0;
            shift_reg      <= 8'd0;
            chars_left_reg <= 3'd0;
            dig_cnt_reg    <= 3'd0;
            dig_idx_reg    <= 3'd0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                bit_period_reg <= cfg_wr_data;
            end
            phase_reg      <= phase_next;
            bit_index_reg  <= bit_index_next;
            tick_count_reg <= tick_count_next;
            shift_reg      <= shift_next;
            chars_left_reg <= chars_left_next;
            dig_cnt_reg    <= dig_cnt_next;
            dig_idx_reg    <= dig_idx_next;
            if (q_pop) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        dig_rem_reg <= dig_rem_next;
        if (dig_wr && !load) begin
            char_queue[dig_idx_reg] <= ASCII_ZERO + {4'd0, dig_val};
        end
        if (q_pop) begin
            level_reg  <= level_now;
            driven_reg <= (phase_next == PH_SEND);
            busy_reg   <= (phase_next == PH_SEND) || (phase_next == PH_GAP);
            rej_reg    <= rej_now;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_line_level  = level_reg;
    assign m_line_driven = driven_reg;
    assign m_busy_res    = busy_reg;
    assign m_rejected    = rej_reg;

endmodule

### src/decimal_uart_transmitter.sv
`timescale 1ns / 1ps

// channel   direction  handshake          payload
// s_        in         s_valid/s_ready    s_operation[1:0], s_value[15:0]
// m_        out        m_valid/m_ready    m_line_level, m_line_driven, m_busy_res, m_rejected
// cfg_      in         cfg_wr_en          cfg_wr_data[15:0] (bit_period)
//
// one request per cycle sustained while m_ready is high; each request is held in the
// two-entry queue between classifier and line engine, then its result in output registers
// m_ stalls back up into the queue, s_ready drops only when the queue is full
// reset (aresetn low, synchronous) empties the queue, idles the line, bit_period = 104
// trailing decimal digits are built one per cycle after a send, well before they are needed

module decimal_uart_transmitter (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,
    // request channel
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_operation,
    input  logic [15:0] s_value,
    // result channel
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_line_level,
    output logic        m_line_driven,
    output logic        m_busy_res,
    output logic        m_rejected
);
    import duart_pkg::*;

    item_t front_item;
    item_t head_item;
    logic  q_full;
    logic  q_valid;
    logic  q_pop;
    logic  push;

    // request taken whenever the queue has room
    assign s_ready = !q_full;
    assign push    = s_valid && s_ready;

    // classify the request and peel off the leading character
    duart_front u_front (
        .operation (s_operation),
        .value     (s_value),
        .item      (front_item)
    );

    // decouples classification from the line engine
    duart_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_item (front_item),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_valid),
        .head      (head_item)
    );

    // bit timing, gap, character sequencing and digit builder
    duart_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .q_valid       (q_valid),
        .q_item        (head_item),
        .q_pop         (q_pop),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_line_level  (m_line_level),
        .m_line_driven (m_line_driven),
        .m_busy_res    (m_busy_res),
        .m_rejected    (m_rejected)
    );

endmodule

### src/duart_checker.sv
`timescale 1ns / 1ps

module duart_checker (
    input logic aclk,
    input logic aresetn,
    input logic m_valid,
    input logic m_ready,
    input logic m_line_level,
    input logic m_line_driven,
    input logic m_busy_res,
    input logic m_rejected
);

    // a driven line means a character is in flight
    a_driven_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_line_driven) |-> m_busy_res)
        else $error("line driven while not busy");

    // refusal only happens while busy, and leaves the block busy
    a_reject_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_rejected) |-> m_busy_res)
        else $error("request rejected while idle");

    // released line always reads high
    a_release_high: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_line_driven) |-> m_line_level)
        else $error("line low while released");

    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> m_valid)
        else $error("result dropped before it was taken");

endmodule

bind decimal_uart_transmitter duart_checker u_duart_checker (.*);
